### design/fdc16_pkg.sv
// Package for the frame deframer: constants, status codes, result type and CRC byte update.
`timescale 1ns / 1ps
package fdc16_pkg;

	localparam logic [15:0] CrcInit  = 16'hFFFF;
	localparam logic [15:0] CrcPoly  = 16'h1021;
	localparam logic [15:0] CrcTop   = 16'h8000;

	localparam int unsigned CountW   = 17;
	localparam logic [CountW-1:0] CountMax = 17'h1FFFF;
	localparam logic [CountW-1:0] HdrBytes = 17'd5;
	localparam logic [CountW-1:0] OvhBytes = 17'd7;

	localparam int unsigned CfgAddrW = 2;
	localparam logic [CfgAddrW-1:0] RegMagicFirst  = 2'd0;
	localparam logic [CfgAddrW-1:0] RegMagicSecond = 2'd1;
	localparam logic [CfgAddrW-1:0] RegVersion     = 2'd2;
	localparam logic [CfgAddrW-1:0] RegMaxPayload  = 2'd3;

	localparam logic [15:0] MaxPayloadReset = 16'd256;

	localparam logic [2:0] StOk         = 3'd0;
	localparam logic [2:0] StIncomplete = 3'd1;
	localparam logic [2:0] StBadMagic   = 3'd2;
	localparam logic [2:0] StBadVersion = 3'd3;
	localparam logic [2:0] StLength     = 3'd4;
	localparam logic [2:0] StCrc        = 3'd5;

	localparam int unsigned InDataW  = 8;
	localparam int unsigned OutDataW = 32;

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoPtrW  = 2;
	localparam int unsigned FifoCntW  = 3;

	typedef struct packed {
		logic [OutDataW-1:0] data;
		logic                user;
		logic                last;
	} res_t;

	// MSB-first CRC-16 update with one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CrcTop) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### design/frame_deframer_crc16_check.sv
// Frame deframer: header check, payload pass-through, CRC-16/CCITT-FALSE and status.
`timescale 1ns / 1ps
// Takes one frame byte per cycle. Each byte is parsed in the cycle it is
// accepted: header compare, byte-wide CRC update and length checks sit in one
// combinational stage ahead of a four-entry result queue. A byte yields no
// result, a payload item, a status item (tlast), or both; the queue drains one
// item per cycle while m_tready is high; a byte that is both payload and frame
// end takes two entries. s_tready stays high while the queue holds at most two
// items, so input runs at one byte per clock as long as the consumer keeps up.
// Payload items (tuser high) go out only while the header is valid; they should
// be dropped unless the closing status is ok. Configuration writes are taken
// at any time but belong between frames.
module frame_deframer_crc16_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fdc16_pkg::CfgAddrW-1:0] cfg_addr,
	input  logic [15:0]                    cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fdc16_pkg::InDataW-1:0]  s_tdata,   // [7:0] data_byte
	input  logic                           s_tlast,   // frame_end
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fdc16_pkg::OutDataW-1:0] m_tdata,   // [7:0] payload_byte, [10:8] status,
	                                                  // [26:11] payload_length, rest zero
	output logic                           m_tuser,   // is_payload
	output logic                           m_tlast    // frame_done
);
	import fdc16_pkg::*;

	logic [7:0]  magic_first_q;
	logic [7:0]  magic_second_q;
	logic [7:0]  version_q;
	logic [15:0] max_payload_q;

	logic [CountW-1:0] cnt_q;
	logic [15:0]       crc_q;
	logic [15:0]       len_q;
	logic [15:0]       rxcrc_q;
	logic              mgood_q;
	logic              vgood_q;

	res_t                fifo_q [FifoDepth];
	logic [FifoPtrW-1:0] wr_ptr_q;
	logic [FifoPtrW-1:0] rd_ptr_q;
	logic [FifoCntW-1:0] count_q;

	logic              s_acc;
	logic              pop;
	logic [7:0]        b;
	logic [CountW-1:0] off;
	logic [CountW-1:0] len_ext;
	logic              in_payload;
	logic              crc_en;
	logic [15:0]       crc_upd;
	logic [CountW-1:0] cnt_next;
	logic [15:0]       crc_next;
	logic [15:0]       len_next;
	logic [15:0]       rxcrc_next;
	logic              mgood_next;
	logic              vgood_next;
	logic              emit_pl;
	logic [CountW-1:0] expected;
	logic [2:0]        st;
	logic [15:0]       plen;
	res_t              pl_res;
	res_t              st_res;
	res_t              first_res;
	logic [1:0]        n_push;

	assign s_acc    = s_tvalid && s_tready;
	assign s_tready = (count_q < FifoCntW'(3));
	assign m_tvalid = (count_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = fifo_q[rd_ptr_q].data;
	assign m_tuser  = fifo_q[rd_ptr_q].user;
	assign m_tlast  = fifo_q[rd_ptr_q].last;

	assign b       = s_tdata[7:0];
	assign off     = cnt_q - HdrBytes;
	assign len_ext = {1'b0, len_q};
	assign crc_upd = crc_byte(crc_q, b);

	always_comb begin
		mgood_next = mgood_q;
		vgood_next = vgood_q;
		len_next   = len_q;
		rxcrc_next = rxcrc_q;
		in_payload = 1'b0;
		crc_en     = 1'b0;
		case (cnt_q)
			17'd0: mgood_next = (b == magic_first_q);
			17'd1: mgood_next = mgood_q && (b == magic_second_q);
			17'd2: begin
				vgood_next = (b == version_q);
				crc_en     = 1'b1;
			end
			17'd3: begin
				len_next = {8'h00, b};
				crc_en   = 1'b1;
			end
			17'd4: begin
				len_next = {b, len_q[7:0]};
				crc_en   = 1'b1;
			end
			default: begin
				if (off < len_ext) begin
					in_payload = 1'b1;
					crc_en     = 1'b1;
				end else if (off == len_ext) begin
					rxcrc_next = {8'h00, b};
				end else if (off == len_ext + 17'd1) begin
					rxcrc_next = {b, rxcrc_q[7:0]};
				end
			end
		endcase
		crc_next = crc_en ? crc_upd : crc_q;
		cnt_next = (cnt_q < CountMax) ? cnt_q + 17'd1 : cnt_q;
	end

	assign emit_pl  = in_payload && mgood_q && vgood_q && (len_q <= max_payload_q);
	assign expected = {1'b0, len_next} + OvhBytes;

	always_comb begin
		if (cnt_next < HdrBytes) begin
			st = StIncomplete;
		end else if (!mgood_next) begin
			st = StBadMagic;
		end else if (!vgood_next) begin
			st = StBadVersion;
		end else if (len_next > max_payload_q) begin
			st = StLength;
		end else if (cnt_next < expected) begin
			st = StIncomplete;
		end else if (cnt_next != expected) begin
			st = StLength;
		end else if (rxcrc_next != crc_next) begin
			st = StCrc;
		end else begin
			st = StOk;
		end
	end

	assign plen      = (st == StOk) ? len_next : 16'h0000;
	assign pl_res    = '{data: {24'h000000, b}, user: 1'b1, last: 1'b0};
	assign st_res    = '{data: {5'b00000, plen, st, 8'h00}, user: 1'b0, last: 1'b1};
	assign first_res = emit_pl ? pl_res : st_res;
	assign n_push    = s_acc ? ({1'b0, emit_pl} + {1'b0, s_tlast}) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q  <= '0;
			magic_second_q <= '0;
			version_q      <= '0;
			max_payload_q  <= MaxPayloadReset;
		end else if (cfg_we) begin
			case (cfg_addr)
				RegMagicFirst:  magic_first_q  <= cfg_wdata[7:0];
				RegMagicSecond: magic_second_q <= cfg_wdata[7:0];
				RegVersion:     version_q      <= cfg_wdata[7:0];
				RegMaxPayload:  max_payload_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			crc_q   <= CrcInit;
			len_q   <= '0;
			rxcrc_q <= '0;
			mgood_q <= 1'b1;
			vgood_q <= 1'b1;
		end else if (s_acc) begin
			if (s_tlast) begin
				cnt_q   <= '0;
				crc_q   <= CrcInit;
				len_q   <= '0;
				rxcrc_q <= '0;
				mgood_q <= 1'b1;
				vgood_q <= 1'b1;
			end else begin
				cnt_q   <= cnt_next;
				crc_q   <= crc_next;
				len_q   <= len_next;
				rxcrc_q <= rxcrc_next;
				mgood_q <= mgood_next;
				vgood_q <= vgood_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FifoPtrW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
			end
			count_q <= count_q + FifoCntW'(n_push) - FifoCntW'(pop);
		end
	end

	// result storage, no reset needed
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= first_res;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_q + FifoPtrW'(1)] <= st_res;
		end
	end

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FifoCntW'(FifoDepth))
		else $error("result queue over depth");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tlast |=> cnt_q == '0 && crc_q == CrcInit)
		else $error("frame state not cleared after frame end");

	a_payload_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && emit_pl |-> mgood_q && vgood_q && cnt_q >= HdrBytes)
		else $error("payload item with bad header");

	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tuser && m_tdata[7:0] == 8'h00)
		else $error("status item marked as payload");

endmodule
